### src/adc_battery_voltage_monitor_assert.svh
// ----------------------------------------------------------------------------
// battery monitor assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ADC_BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define ADC_BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`ifndef SYNTH
// property holds on every clock outside reset
`define ABVM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ABVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ABVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ABVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/abvm_pkg.sv
// ----------------------------------------------------------------------------
// battery monitor package
// shared widths, register indexes, reset values, sequencer states
// ----------------------------------------------------------------------------
package abvm_pkg;

	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_Q_W   = 16;
	localparam int DIV_CNT_W = 5;

	localparam int MV_W    = 16;
	localparam int GAIN_W  = 24;
	localparam int MUL_A_W = 17;
	localparam int MUL_P_W = MUL_A_W + GAIN_W;
	localparam int T_W     = 18;
	localparam int TOTAL_W = 48;
	localparam int COUNT_W = 32;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_RUNNING    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;

	localparam logic OP_STORE   = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	localparam logic [MV_W-1:0]   FULL_SCALE_RST = 16'd6600;
	localparam logic [MV_W-1:0]   MV_MAX         = 16'hFFFF;
	localparam logic [GAIN_W-1:0] GAIN_RST       = 24'd65536;
	localparam logic [MV_W:0]     REARM_MV       = 17'd500;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DIV_AVG,
		ST_MUL_MV,
		ST_DIV_MV,
		ST_MUL_GAIN,
		ST_UPDATE,
		ST_STAT_GO,
		ST_DIV_STAT
	} state_t;

	typedef struct packed {
		logic store;
		logic zero_res;
		logic sweep_go;
		logic rd_issue;
		logic div_start;
		logic ld_avg;
		logic ld_mv;
		logic ld_prod;
		logic update;
		logic ld_res;
	} ctl_t;

endpackage

### src/abvm_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module abvm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/abvm_div.sv
// ----------------------------------------------------------------------------
// shared restoring divider
// one quotient bit per cycle, sixteen steps; quotient must fit sixteen bits
// ----------------------------------------------------------------------------
`include "adc_battery_voltage_monitor_assert.svh"

module abvm_div import abvm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] numer,
	input  logic [DIV_DEN_W-1:0] denom,
	output logic [DIV_Q_W-1:0]   quot,
	output logic                 done
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, quo_q[DIV_Q_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high part preloads the remainder; low part shifts into it as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[DIV_NUM_W-1:DIV_Q_W];
			quo_q <= numer[DIV_Q_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

	`ABVM_ASSERT(a_div_no_restart, clk, arst_n, !(start && busy_q), "divider restarted while busy")
	`ABVM_ASSERT(a_div_rem_bound, clk, arst_n, !busy_q || (rem_q < den_q), "partial remainder not below divisor")
	`ABVM_ASSERT(a_div_cnt_live, clk, arst_n, !busy_q || (cnt_q != '0), "divider busy with no steps left")

endmodule

### src/adc_battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery voltage monitor: sample ring, calibrated average, stats and alarm
// store beat: written to the ring on accept. measure beat while running: one ring
// read per cycle on the ram port, then three 16-step divider passes (all-zero result when stopped).
// one measure in flight; a new measure waits until the result beat is taken.
// reset: config to defaults, ring empty (reads as zero), stats and alarm cleared
// ----------------------------------------------------------------------------
`include "adc_battery_voltage_monitor_assert.svh"

module adc_battery_voltage_monitor import abvm_pkg::*; #(
	parameter int WINDOW_DEPTH = 16,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   op,
	input  logic [SAMPLE_BITS-1:0] raw_sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   valid_res,
	output logic [MV_W-1:0]        voltage_mv,
	output logic                   alarm,
	output logic                   healthy,
	output logic [SAMPLE_BITS-1:0] latest_raw,
	output logic [MV_W-1:0]        min_mv,
	output logic [MV_W-1:0]        max_mv,
	output logic [MV_W-1:0]        avg_mv,
	output logic                   stats_valid,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + IDX_W;
	localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(WINDOW_DEPTH);
	localparam logic [DIV_DEN_W-1:0] DEPTH_DEN = DIV_DEN_W'(WINDOW_DEPTH);
	localparam logic [DIV_DEN_W-1:0] CODE_MAX  = DIV_DEN_W'((1 << SAMPLE_BITS) - 1);

	// configuration
	logic                 run_q;
	logic [MV_W-1:0]      fs_q;
	logic [MV_W-1:0]      off_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [MV_W-1:0]      thr_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// sequencer
	state_t state_q;
	state_t state_nxt;
	ctl_t   ctl;
	logic   item_acc;
	logic   res_acc;

	// ring
	logic [IDX_W-1:0]       wp_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SAMPLE_BITS-1:0] latest_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   issuing_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   rd_last_s1;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] samp_val;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       sum_nxt;
	logic [SAMPLE_BITS-1:0] ref_q;
	logic                   hlt_q;

	// calibration datapath
	logic [SAMPLE_BITS-1:0] avg_q;
	logic signed [T_W-1:0]  t_q;
	logic                   t_pos;
	logic [MUL_A_W-1:0]     mul_a;
	logic [GAIN_W-1:0]      mul_b;
	logic [MUL_P_W-1:0]     mul_p;
	logic [MUL_P_W-1:0]     prod_q;
	logic [MV_W-1:0]        v;
	logic [MV_W-1:0]        v_q;
	logic                   alm_nxt;
	logic                   alm_out_q;

	// statistics
	logic               alm_latched_q;
	logic [MV_W-1:0]    min_q;
	logic [MV_W-1:0]    max_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;

	// divider
	logic [DIV_NUM_W-1:0] div_numer;
	logic [DIV_DEN_W-1:0] div_denom;
	logic [DIV_Q_W-1:0]   div_quot;
	logic                 div_done;

	// result register
	logic                   res_vld_q;
	logic                   r_valid_q;
	logic [MV_W-1:0]        r_volt_q;
	logic                   r_alarm_q;
	logic                   r_healthy_q;
	logic [SAMPLE_BITS-1:0] r_latest_q;
	logic [MV_W-1:0]        r_min_q;
	logic [MV_W-1:0]        r_max_q;
	logic [MV_W-1:0]        r_avg_q;
	logic                   r_stats_q;

	// ------------------------------------------------------------------ apb

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fs_q   <= FULL_SCALE_RST;
			off_q  <= '0;
			gain_q <= GAIN_RST;
			thr_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RUNNING:    run_q  <= pwdata[0];
				REG_FULL_SCALE: fs_q   <= pwdata[MV_W-1:0];
				REG_OFFSET:     off_q  <= pwdata[MV_W-1:0];
				REG_GAIN:       gain_q <= pwdata[GAIN_W-1:0];
				REG_THRESHOLD:  thr_q  <= pwdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RUNNING:    prdata = APB_DW'(run_q);
			REG_FULL_SCALE: prdata = APB_DW'(fs_q);
			REG_OFFSET:     prdata = APB_DW'(off_q);
			REG_GAIN:       prdata = APB_DW'(gain_q);
			REG_THRESHOLD:  prdata = APB_DW'(thr_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ sequencer

	assign item_stall = (state_q != ST_IDLE) || (res_vld_q && op == OP_MEASURE);
	assign item_acc   = item_valid && !item_stall;
	assign res_acc    = result_valid && !result_stall;
	assign rd_last_s1 = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc && op == OP_MEASURE && run_q) begin
					state_nxt = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (rd_last_s1) begin
					state_nxt = ST_DIV_AVG;
				end
			end
			ST_DIV_AVG: begin
				if (div_done) begin
					state_nxt = ST_MUL_MV;
				end
			end
			ST_MUL_MV:   state_nxt = ST_DIV_MV;
			ST_DIV_MV: begin
				if (div_done) begin
					state_nxt = ST_MUL_GAIN;
				end
			end
			ST_MUL_GAIN: state_nxt = ST_UPDATE;
			ST_UPDATE:   state_nxt = ST_STAT_GO;
			ST_STAT_GO:  state_nxt = ST_DIV_STAT;
			ST_DIV_STAT: begin
				if (div_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.store    = item_acc && op == OP_STORE;
				ctl.zero_res = item_acc && op == OP_MEASURE && !run_q;
				ctl.sweep_go = item_acc && op == OP_MEASURE && run_q;
			end
			ST_SWEEP: begin
				ctl.rd_issue  = issuing_q;
				ctl.div_start = rd_last_s1;
			end
			ST_DIV_AVG:  ctl.ld_avg    = div_done;
			ST_MUL_MV:   ctl.div_start = 1'b1;
			ST_DIV_MV:   ctl.ld_mv     = div_done;
			ST_MUL_GAIN: ctl.ld_prod   = 1'b1;
			ST_UPDATE:   ctl.update    = 1'b1;
			ST_STAT_GO:  ctl.div_start = 1'b1;
			ST_DIV_STAT: ctl.ld_res    = div_done;
			default: ;
		endcase
	end

	// ----------------------------------------------------------------- ring

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			latest_q <= '0;
		end else if (ctl.store) begin
			wp_q     <= (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
			latest_q <= raw_sample;
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	abvm_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ctl.store),
		.waddr (wp_q),
		.wdata (raw_sample),
		.re    (ctl.rd_issue),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			issuing_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.rd_issue;
			if (ctl.sweep_go) begin
				idx_q     <= '0;
				issuing_q <= 1'b1;
			end else if (ctl.rd_issue) begin
				if (idx_q == LAST_IDX) begin
					issuing_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// entries never written since reset read as zero
	assign samp_val = (FILL_W'(rd_idx_s1) < fill_q) ? ram_rdata : '0;
	assign sum_nxt  = sum_q + SUM_W'(samp_val);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (rd_vld_s1) begin
			if (rd_idx_s1 == '0) begin
				sum_q <= SUM_W'(samp_val);
				ref_q <= samp_val;
				hlt_q <= 1'b0;
			end else begin
				sum_q <= sum_nxt;
				if (samp_val != ref_q) begin
					hlt_q <= 1'b1;
				end
			end
		end
	end

	// ----------------------------------------------------- shared arithmetic

	always_comb begin
		case (state_q)
			ST_SWEEP: begin
				div_numer = DIV_NUM_W'(sum_nxt);
				div_denom = DEPTH_DEN;
			end
			ST_MUL_MV: begin
				div_numer = DIV_NUM_W'(mul_p);
				div_denom = CODE_MAX;
			end
			default: begin
				div_numer = total_q;
				div_denom = count_q;
			end
		endcase
	end

	abvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.quot   (div_quot),
		.done   (div_done)
	);

	assign t_pos = !t_q[T_W-1] && (t_q != '0);

	always_comb begin
		if (state_q == ST_MUL_GAIN) begin
			mul_a = t_pos ? t_q[MUL_A_W-1:0] : '0;
			mul_b = gain_q;
		end else begin
			mul_a = MUL_A_W'(avg_q);
			mul_b = GAIN_W'(fs_q);
		end
	end

	assign mul_p = {{GAIN_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	// drop the q16 fraction, saturate to 16 bits
	assign v = (|prod_q[MUL_P_W-1:2*MV_W]) ? MV_MAX : prod_q[2*MV_W-1:MV_W];

	assign alm_nxt = (thr_q != '0) && (v < thr_q) && !alm_latched_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_avg) begin
			avg_q <= div_quot[SAMPLE_BITS-1:0];
		end
		if (ctl.ld_mv) begin
			t_q <= $signed({2'b00, div_quot}) + $signed({{2{off_q[MV_W-1]}}, off_q});
		end
		if (ctl.ld_prod) begin
			prod_q <= mul_p;
		end
		if (ctl.update) begin
			v_q       <= v;
			alm_out_q <= alm_nxt;
		end
	end

	// ----------------------------------------------------------- statistics

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alm_latched_q <= 1'b0;
			min_q         <= MV_MAX;
			max_q         <= '0;
			total_q       <= '0;
			count_q       <= '0;
		end else if (cfg_wr && cfg_idx == REG_THRESHOLD) begin
			alm_latched_q <= 1'b0;
		end else if (ctl.update) begin
			if (v < min_q) begin
				min_q <= v;
			end
			if (v > max_q) begin
				max_q <= v;
			end
			// sum and count freeze once the count saturates
			if (count_q != '1) begin
				total_q <= total_q + TOTAL_W'(v);
				count_q <= count_q + COUNT_W'(1);
			end
			if (thr_q != '0) begin
				if (alm_nxt) begin
					alm_latched_q <= 1'b1;
				end else if ({1'b0, v} >= ({1'b0, thr_q} + REARM_MV)) begin
					alm_latched_q <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------- result

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ctl.ld_res || ctl.zero_res) begin
			res_vld_q <= 1'b1;
		end else if (res_acc) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_res) begin
			r_valid_q   <= 1'b1;
			r_volt_q    <= v_q;
			r_alarm_q   <= alm_out_q;
			r_healthy_q <= hlt_q;
			r_latest_q  <= latest_q;
			r_min_q     <= min_q;
			r_max_q     <= max_q;
			r_avg_q     <= div_quot;
			r_stats_q   <= 1'b1;
		end else if (ctl.zero_res) begin
			r_valid_q   <= 1'b0;
			r_volt_q    <= '0;
			r_alarm_q   <= 1'b0;
			r_healthy_q <= 1'b0;
			r_latest_q  <= '0;
			r_min_q     <= '0;
			r_max_q     <= '0;
			r_avg_q     <= '0;
			r_stats_q   <= 1'b0;
		end
	end

	assign result_valid = res_vld_q;
	assign valid_res    = r_valid_q;
	assign voltage_mv   = r_volt_q;
	assign alarm        = r_alarm_q;
	assign healthy      = r_healthy_q;
	assign latest_raw   = r_latest_q;
	assign min_mv       = r_min_q;
	assign max_mv       = r_max_q;
	assign avg_mv       = r_avg_q;
	assign stats_valid  = r_stats_q;

	`ABVM_ASSERT(a_fill_bound, clk, arst_n, fill_q <= FILL_FULL, "ring fill count past depth")
	`ABVM_ASSERT(a_min_le_max, clk, arst_n, (count_q == '0) || (min_q <= max_q), "min above max after a measure")
	`ABVM_ASSERT_NEXT(a_alarm_latches, clk, arst_n, ctl.update && alm_nxt, alm_latched_q, "alarm fired without latching")
	`ABVM_ASSERT(a_no_overwrite, clk, arst_n, !((ctl.ld_res || ctl.zero_res) && res_vld_q), "result loaded over a pending beat")

endmodule

### tb/sv/tb_adc_battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery voltage monitor testbench
// feeds sample and measure beats in random bursts, writes calibration over the
// apb port between phases, and compares every reading with a local model of
// the ring average, calibration, running stats, hysteresis alarm and stuck check
// ----------------------------------------------------------------------------
module tb_adc_battery_voltage_monitor import abvm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = 16;
	localparam int SAMPLE_W   = 12;
	localparam int CODE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int SETTLE     = 100;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 50;

	typedef struct packed {
		logic                valid_res;
		logic [MV_W-1:0]     voltage_mv;
		logic                alarm;
		logic                healthy;
		logic [SAMPLE_W-1:0] latest_raw;
		logic [MV_W-1:0]     min_mv;
		logic [MV_W-1:0]     max_mv;
		logic [MV_W-1:0]     avg_mv;
		logic                stats_valid;
	} reading_t;

	typedef struct packed {
		logic                op;
		logic [SAMPLE_W-1:0] raw;
	} sample_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_STORE;
	logic [SAMPLE_W-1:0] raw_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic valid_res;
	logic [MV_W-1:0] voltage_mv;
	logic alarm;
	logic healthy;
	logic [SAMPLE_W-1:0] latest_raw;
	logic [MV_W-1:0] min_mv;
	logic [MV_W-1:0] max_mv;
	logic [MV_W-1:0] avg_mv;
	logic stats_valid;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// model of the block
	logic                cfg_running;
	logic [MV_W-1:0]     cfg_fs;
	logic signed [MV_W-1:0] cfg_offset;
	logic [GAIN_W-1:0]   cfg_gain;
	logic [MV_W-1:0]     cfg_thr;
	logic [SAMPLE_W-1:0] sim_ring [DEPTH];
	logic [3:0]          sim_wp;
	logic                sim_latched;
	logic [MV_W-1:0]     sim_min;
	logic [MV_W-1:0]     sim_max;
	logic [TOTAL_W-1:0]  sim_total;
	logic [COUNT_W-1:0]  sim_count;

	sample_req_t pending_q [$];
	reading_t    reading_q [$];
	int items_open = 0;
	int mismatch_count = 0;
	int readings_taken = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_tick = 0;
	int idle_cycles = 0;

	adc_battery_voltage_monitor #(
		.WINDOW_DEPTH(DEPTH),
		.SAMPLE_BITS (SAMPLE_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.raw_sample  (raw_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.valid_res   (valid_res),
		.voltage_mv  (voltage_mv),
		.alarm       (alarm),
		.healthy     (healthy),
		.latest_raw  (latest_raw),
		.min_mv      (min_mv),
		.max_mv      (max_mv),
		.avg_mv      (avg_mv),
		.stats_valid (stats_valid),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ring average -> millivolts -> offset -> q16 gain, saturated
	function automatic logic [MV_W-1:0] scale_to_mv(input logic [SAMPLE_W-1:0] avg);
		longint mv;
		longint t;
		longint p;
		mv = (longint'(avg) * longint'(cfg_fs)) / CODE_MAX;
		t = mv + longint'(cfg_offset);
		if (t <= 0)
			return '0;
		p = (t * longint'(cfg_gain)) >>> 16;
		return (p > longint'(MV_MAX)) ? MV_MAX : p[MV_W-1:0];
	endfunction

	function automatic void battery_step(input logic op_b, input logic [SAMPLE_W-1:0] raw_b);
		reading_t r;
		logic [15:0] ring_sum;
		logic [MV_W-1:0] v;
		logic [TOTAL_W-1:0] mean;
		r = '0;
		if (op_b == OP_STORE) begin
			sim_ring[sim_wp] = raw_b;
			sim_wp = sim_wp + 4'd1;
			return;
		end
		if (cfg_running) begin
			ring_sum = '0;
			for (int i = 0; i < DEPTH; i++)
				ring_sum = ring_sum + sim_ring[i];
			v = scale_to_mv(ring_sum[15:4]);
			if (v < sim_min)
				sim_min = v;
			if (v > sim_max)
				sim_max = v;
			if (sim_count != '1) begin
				sim_total = sim_total + v;
				sim_count = sim_count + 1;
			end
			if (cfg_thr != '0) begin
				if (v < cfg_thr && !sim_latched) begin
					sim_latched = 1'b1;
					r.alarm = 1'b1;
				end
				if ({1'b0, v} >= {1'b0, cfg_thr} + REARM_MV)
					sim_latched = 1'b0;
			end
			for (int i = 1; i < DEPTH; i++)
				if (sim_ring[i] != sim_ring[0])
					r.healthy = 1'b1;
			mean = sim_total / sim_count;
			r.valid_res = 1'b1;
			r.voltage_mv = v;
			r.latest_raw = sim_ring[sim_wp - 4'd1];
			r.min_mv = sim_min;
			r.max_mv = sim_max;
			r.avg_mv = mean[MV_W-1:0];
			r.stats_valid = 1'b1;
		end
		reading_q.push_back(r);
	endfunction

	task automatic check_field(input string fld, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
			mismatch_count++;
		end
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RUNNING:    cfg_running = value[0];
			REG_FULL_SCALE: cfg_fs = value[MV_W-1:0];
			REG_OFFSET:     cfg_offset = value[MV_W-1:0];
			REG_GAIN:       cfg_gain = value[GAIN_W-1:0];
			REG_THRESHOLD: begin
				cfg_thr = value[MV_W-1:0];
				sim_latched = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic set_config(input logic run, input logic [MV_W-1:0] fs,
			input logic [MV_W-1:0] off, input logic [GAIN_W-1:0] gain,
			input logic [MV_W-1:0] thr);
		apb_write(REG_RUNNING, {31'd0, run});
		apb_write(REG_FULL_SCALE, {16'd0, fs});
		apb_write(REG_OFFSET, {{16{off[15]}}, off});
		apb_write(REG_GAIN, {8'd0, gain});
		apb_write(REG_THRESHOLD, {16'd0, thr});
	endtask

	task automatic push_item(input logic op_b, input logic [SAMPLE_W-1:0] raw_b);
		sample_req_t s;
		s.op = op_b;
		s.raw = raw_b;
		pending_q.push_back(s);
		items_open++;
	endtask

	task automatic wait_idle();
		while (items_open != 0 || reading_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly fill-then-measure sequences around a level, some noise
	task automatic push_random_items(input int target);
		int added;
		int kind;
		int level;
		int n;
		int raw_i;
		bit stuck;
		added = 0;
		while (added < target) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				level = $urandom_range(0, CODE_MAX);
				stuck = ($urandom_range(0, 5) == 0);
				n = stuck ? DEPTH : $urandom_range(1, DEPTH);
				for (int k = 0; k < n; k++) begin
					raw_i = stuck ? level : level + $urandom_range(0, 80) - 40;
					if (raw_i < 0)
						raw_i = 0;
					if (raw_i > CODE_MAX)
						raw_i = CODE_MAX;
					push_item(OP_STORE, raw_i[SAMPLE_W-1:0]);
					added++;
				end
				push_item(OP_MEASURE, $urandom_range(0, CODE_MAX));
				added++;
			end else if (kind == 7) begin
				push_item(OP_STORE, $urandom_range(0, CODE_MAX));
				added++;
			end else if (kind == 8) begin
				push_item(OP_MEASURE, $urandom_range(0, CODE_MAX));
				added++;
			end else begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) begin
					push_item(OP_STORE, $urandom_range(0, CODE_MAX));
					added++;
				end
			end
		end
	endtask

	// sender: bursts of beats with random gaps, model updated on each accepted beat
	always @(posedge clk) begin
		sample_req_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				battery_step(op, raw_sample);
				items_open--;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					item_valid <= 1'b0;
					gap_left--;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					item_valid <= 1'b1;
					op <= nxt.op;
					raw_sample <= nxt.raw;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end else begin
						burst_left--;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks readings, stalls in changing modes plus occasional long holds
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (reading_q.size() == 0) begin
					$display("%0t: reading beat with none expected, voltage_mv %0d",
						$time, voltage_mv);
					mismatch_count++;
				end else begin
					want = reading_q.pop_front();
					check_field("valid_res", want.valid_res, valid_res);
					check_field("voltage_mv", want.voltage_mv, voltage_mv);
					check_field("alarm", want.alarm, alarm);
					check_field("healthy", want.healthy, healthy);
					check_field("latest_raw", want.latest_raw, latest_raw);
					check_field("min_mv", want.min_mv, min_mv);
					check_field("max_mv", want.max_mv, max_mv);
					check_field("avg_mv", want.avg_mv, avg_mv);
					check_field("stats_valid", want.stats_valid, stats_valid);
				end
				readings_taken++;
				if (readings_taken % 40 == 7)
					hold_left = $urandom_range(300, 500);
			end
			if (stall_tick == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_tick = $urandom_range(20, 120);
			end else begin
				stall_tick--;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= $urandom_range(0, 1);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("adc_battery_voltage_monitor test failed");
				$finish;
			end
		end
	end

	initial begin
		logic run;
		logic [MV_W-1:0] fs;
		logic signed [MV_W-1:0] off;
		logic [GAIN_W-1:0] gain;
		logic [MV_W-1:0] thr;
		longint vmax;

		cfg_running = 1'b0;
		cfg_fs = FULL_SCALE_RST;
		cfg_offset = '0;
		cfg_gain = GAIN_RST;
		cfg_thr = '0;
		for (int i = 0; i < DEPTH; i++)
			sim_ring[i] = '0;
		sim_wp = '0;
		sim_latched = 1'b0;
		sim_min = MV_MAX;
		sim_max = '0;
		sim_total = '0;
		sim_count = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stopped after reset: reading is all zeros
		push_item(OP_MEASURE, '0);
		push_item(OP_STORE, '0);
		wait_idle();

		// all-zero ring reads as stuck, zero volts fires the alarm
		set_config(1'b1, FULL_SCALE_RST, 16'd0, GAIN_RST, 16'd3000);
		push_item(OP_MEASURE, 12'hFFF);
		push_item(OP_STORE, 12'hFFF);
		push_item(OP_STORE, 12'h555);
		push_item(OP_STORE, 12'hAAA);
		push_item(OP_MEASURE, '0);
		wait_idle();

		// largest scale, offset and gain saturate and rearm the alarm
		set_config(1'b1, MV_MAX, 16'h7FFF, 24'hFFFFFF, 16'd3000);
		push_item(OP_MEASURE, '0);
		wait_idle();

		// negative total clamps to zero, alarm only once while latched
		set_config(1'b1, 16'd1, 16'h8000, 24'd0, MV_MAX);
		push_item(OP_MEASURE, '0);
		push_item(OP_MEASURE, '0);
		wait_idle();

		// ring stuck at full code, alarm disabled
		set_config(1'b1, FULL_SCALE_RST, -16'sd500, GAIN_RST, 16'd0);
		for (int k = 0; k < DEPTH; k++)
			push_item(OP_STORE, 12'hFFF);
		push_item(OP_MEASURE, '0);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			run = (ph == 2) ? 1'b0 : ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 4))
				0: fs = 16'd1;
				1: fs = MV_MAX;
				default: fs = $urandom_range(1000, 20000);
			endcase
			case ($urandom_range(0, 5))
				0: off = 16'sh8000;
				1: off = 16'sh7FFF;
				2: off = '0;
				default: off = $urandom_range(0, 1000) - 500;
			endcase
			case ($urandom_range(0, 5))
				0: gain = '0;
				1: gain = 24'hFFFFFF;
				2: gain = GAIN_RST;
				default: gain = $urandom_range(32768, 98304);
			endcase
			vmax = ((longint'(fs) + longint'(off)) * longint'(gain)) >>> 16;
			if (vmax < 1)
				vmax = 1;
			if (vmax > 65535)
				vmax = 65535;
			case ($urandom_range(0, 9))
				0: thr = '0;
				1: thr = MV_MAX;
				default: thr = $urandom_range(1, int'(vmax));
			endcase
			set_config(run, fs, off, gain, thr);
			push_random_items(PHASE_LEN);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("adc_battery_voltage_monitor test passed");
		else
			$display("adc_battery_voltage_monitor test failed");
		$finish;
	end

endmodule
